// ===== rtl/srm_pkg.sv =====
// Shared constants, codes and types of the sorted range map.
package srm_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CODE_W      = 32;
    localparam int VAL_W       = 16;
    localparam int FUNC_W      = 3;
    localparam int EIDX_W      = 5;
    localparam int POS_W       = 6;
    localparam int STAT_W      = 2;

    localparam logic [CODE_W-1:0] NO_UPPER = 32'hffff_ffff;

    typedef enum logic [FUNC_W-1:0] {
        FN_LOOKUP      = 3'd0,
        FN_ADD         = 3'd1,
        FN_REMOVE_CODE = 3'd2,
        FN_REMOVE_RNG  = 3'd3,
        FN_CLEAR       = 3'd4,
        FN_SET_NOTHING = 3'd5,
        FN_READ_INDEX  = 3'd6,
        FN_NOP         = 3'd7
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        SS_OK        = 2'd0,
        SS_MISS      = 2'd1,
        SS_FULL      = 2'd2,
        SS_BAD_INDEX = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_DROP,
        S_INS
    } t_state;

    typedef enum logic [2:0] {
        CA_HOLD,
        CA_MARK_NONE,
        CA_MARK_HIT,
        CA_MARK_OVL,
        CA_DROP,
        CA_INS
    } t_cell_act;

    typedef struct packed {
        logic [CODE_W-1:0] low;
        logic [CODE_W-1:0] high;
        logic [VAL_W-1:0]  value;
        logic              mark;
    } t_entry;

    typedef struct packed {
        t_cell_act         act;
        logic [CNT_W-1:0]  count;
        logic [CNT_W-1:0]  pos;
        logic [CODE_W-1:0] key;
        logic [CODE_W-1:0] last;
        t_entry            fresh;
    } t_cell_cmd;

    typedef struct packed {
        logic below;
        logic at;
        logic hit;
        logic ovl;
        logic prev;
    } t_cell_flags;

endpackage

// ===== rtl/srm_cell.sv =====
// One table slot: holds an entry, compares it with the key and shifts with its neighbors.
module srm_cell import srm_pkg::*; (
    input  logic                 i_clk,
    input  logic [IDX_W-1:0]     i_index,
    input  t_cell_cmd            i_cmd,
    input  t_entry               i_left,
    input  t_entry               i_right,
    input  logic                 i_left_below,
    input  logic                 i_right_below,
    output t_entry               o_entry,
    output t_cell_flags          o_flags
);

    t_entry           r_entry;
    t_entry           n_entry;
    logic [CNT_W-1:0] w_index;
    logic             w_valid;
    logic             w_below;
    logic             w_open;

    assign w_index = CNT_W'(i_index);
    assign w_valid = w_index < i_cmd.count;
    assign w_below = w_valid && (r_entry.high < i_cmd.key);
    // A valid slot that reaches the key lies at or after the located position.
    assign w_open  = w_valid && !w_below;

    assign o_flags.below = w_below;
    assign o_flags.at    = w_open && i_left_below;
    assign o_flags.hit   = w_open && i_left_below && (r_entry.low <= i_cmd.key);
    assign o_flags.ovl   = w_open && (r_entry.low <= i_cmd.last);
    assign o_flags.prev  = w_below && !i_right_below;
    assign o_entry       = r_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_cmd.act)
            CA_MARK_NONE: n_entry.mark = 1'b0;
            CA_MARK_HIT:  n_entry.mark = o_flags.hit;
            CA_MARK_OVL:  n_entry.mark = o_flags.ovl;
            CA_DROP: begin
                if (w_index >= i_cmd.pos) begin
                    n_entry = i_right;
                end
            end
            CA_INS: begin
                if (w_index > i_cmd.pos) begin
                    n_entry = i_left;
                end else if (w_index == i_cmd.pos) begin
                    n_entry = i_cmd.fresh;
                end
            end
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ===== rtl/sorted_range_map_top.sv =====
// Top level of the sorted range map: command port, sequencer and the row of table cells.
//
// The block keeps up to MAX_ENTRIES disjoint inclusive code ranges in ascending order,
// each with a 16-bit value, one range per cell of a shift chain.
// An item is accepted at a rising edge where start is high and busy is low. Its operation
// code selects lookup, add, remove at a code, remove of a range, clear, set-to-nothing or
// read by index. Exactly one result item follows for every accepted item: it is on the
// o_ ports for a single cycle while o_valid is high, and the receiver must take it then.
// The entry count and the nothing flag on the result ports show the table after the
// operation and stay correct for as long as the result is shown.
// Every item first passes the compare step, where all cells compare their bounds with the
// key at once. Lookup, read, clear, set-to-nothing, a missed remove and an add into a
// full table that overlaps no entry then report. Removals walk the chain one entry per
// cycle after the compare step, and an add then opens its slot in the insert step.
// The next item may be accepted in the same cycle in which a result is shown.
// Reset empties the table by setting the count to zero and clears the nothing mark; the
// cell contents are not cleared, as only slots below the count are ever read.
module sorted_range_map_top import srm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [FUNC_W-1:0]    i_func,
    input  logic [CODE_W-1:0]    i_code_point,
    input  logic [CODE_W-1:0]    i_range_start,
    input  logic [CODE_W-1:0]    i_range_end,
    input  logic [VAL_W-1:0]     i_entry_value,
    input  logic [EIDX_W-1:0]    i_entry_index,
    output logic                 o_valid,
    output logic                 o_hit,
    output logic [POS_W-1:0]     o_position,
    output logic [CODE_W-1:0]    o_range_first,
    output logic [CODE_W-1:0]    o_range_last,
    output logic [VAL_W-1:0]     o_value_out,
    output logic [POS_W-1:0]     o_entry_count,
    output logic                 o_nothing_flag,
    output logic [STAT_W-1:0]    o_status
);

    // Sequencer and table state.
    t_state              r_state,   n_state;
    logic [CNT_W-1:0]    r_count,   n_count;
    logic                r_nothing, n_nothing;
    logic [CNT_W-1:0]    r_pos,     n_pos;
    logic                r_valid,   n_valid;

    // Result registers.
    logic                r_hit,     n_hit;
    logic [POS_W-1:0]    r_out_pos, n_out_pos;
    logic [CODE_W-1:0]   r_first,   n_first;
    logic [CODE_W-1:0]   r_last_o,  n_last_o;
    logic [VAL_W-1:0]    r_value,   n_value;
    t_status             r_status,  n_status;

    // Captured item.
    t_func               r_func;
    logic [CODE_W-1:0]   r_key;
    logic [CODE_W-1:0]   r_last;
    logic [VAL_W-1:0]    r_val;
    logic [EIDX_W-1:0]   r_idx;

    logic                w_accept;
    t_cell_act           w_act;
    t_cell_cmd           w_cmd;
    t_entry              w_entry [MAX_ENTRIES];
    t_cell_flags         w_flags [MAX_ENTRIES];

    // One-hot selections over the row of cells.
    logic                w_any_at;
    logic                w_any_hit;
    logic                w_any_ovl;
    logic                w_any_prev;
    logic [CNT_W-1:0]    w_at_pos;
    logic [CODE_W-1:0]   w_at_low;
    logic [CODE_W-1:0]   w_at_high;
    logic [VAL_W-1:0]    w_at_value;
    logic [CODE_W-1:0]   w_prev_high;
    logic [CODE_W-1:0]   w_idx_low;
    logic [CODE_W-1:0]   w_idx_high;
    logic [VAL_W-1:0]    w_idx_value;
    logic                w_idx_ok;
    logic                w_mark_at_pos;
    logic [CNT_W-1:0]    w_lookup_pos;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    // The key is the code for lookups and removal at a code; for an add the start of
    // the range, pulled down to its end when the range is reversed.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= t_func'(i_func);
            r_last <= i_range_end;
            r_val  <= i_entry_value;
            r_idx  <= i_entry_index;
            if (t_func'(i_func) == FN_LOOKUP || t_func'(i_func) == FN_REMOVE_CODE) begin
                r_key <= i_code_point;
            end else if (t_func'(i_func) == FN_ADD && i_range_start > i_range_end) begin
                r_key <= i_range_end;
            end else begin
                r_key <= i_range_start;
            end
        end
    end

    assign w_cmd.act         = w_act;
    assign w_cmd.count       = r_count;
    assign w_cmd.pos         = r_pos;
    assign w_cmd.key         = r_key;
    assign w_cmd.last        = r_last;
    assign w_cmd.fresh.low   = r_key;
    assign w_cmd.fresh.high  = r_last;
    assign w_cmd.fresh.value = r_val;
    assign w_cmd.fresh.mark  = 1'b0;

    // The chain: each cell sees the entries and the below flags of both neighbors.
    for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_left_below;
        logic   w_right_below;

        if (k == 0) begin : g_first
            assign w_left       = '0;
            assign w_left_below = 1'b1;
        end else begin : g_inner_l
            assign w_left       = w_entry[k-1];
            assign w_left_below = w_flags[k-1].below;
        end

        if (k == MAX_ENTRIES - 1) begin : g_last
            assign w_right       = '0;
            assign w_right_below = 1'b0;
        end else begin : g_inner_r
            assign w_right       = w_entry[k+1];
            assign w_right_below = w_flags[k+1].below;
        end

        srm_cell u_cell (
            .i_clk         (i_clk),
            .i_index       (IDX_W'(k)),
            .i_cmd         (w_cmd),
            .i_left        (w_left),
            .i_right       (w_right),
            .i_left_below  (w_left_below),
            .i_right_below (w_right_below),
            .o_entry       (w_entry[k]),
            .o_flags       (w_flags[k])
        );
    end

    // At most one cell raises the at, hit or prev flag, so the selections are plain OR trees.
    always_comb begin
        w_any_at      = 1'b0;
        w_any_hit     = 1'b0;
        w_any_ovl     = 1'b0;
        w_any_prev    = 1'b0;
        w_at_pos      = '0;
        w_at_low      = '0;
        w_at_high     = '0;
        w_at_value    = '0;
        w_prev_high   = '0;
        w_idx_low     = '0;
        w_idx_high    = '0;
        w_idx_value   = '0;
        w_mark_at_pos = 1'b0;
        for (int k = 0; k < MAX_ENTRIES; k++) begin
            w_any_at    = w_any_at   | w_flags[k].at;
            w_any_hit   = w_any_hit  | w_flags[k].hit;
            w_any_ovl   = w_any_ovl  | w_flags[k].ovl;
            w_any_prev  = w_any_prev | w_flags[k].prev;
            w_at_pos    = w_at_pos   | ({CNT_W{w_flags[k].at}} & CNT_W'(k));
            w_at_low    = w_at_low   | ({CODE_W{w_flags[k].at}} & w_entry[k].low);
            w_at_high   = w_at_high  | ({CODE_W{w_flags[k].at}} & w_entry[k].high);
            w_at_value  = w_at_value | ({VAL_W{w_flags[k].at}} & w_entry[k].value);
            w_prev_high = w_prev_high | ({CODE_W{w_flags[k].prev}} & w_entry[k].high);
            w_idx_low   = w_idx_low  | ({CODE_W{k == int'(r_idx)}} & w_entry[k].low);
            w_idx_high  = w_idx_high | ({CODE_W{k == int'(r_idx)}} & w_entry[k].high);
            w_idx_value = w_idx_value | ({VAL_W{k == int'(r_idx)}} & w_entry[k].value);
            w_mark_at_pos = w_mark_at_pos | (w_entry[k].mark && (CNT_W'(k) == r_pos));
        end
    end

    assign w_idx_ok     = int'(r_idx) < int'(r_count);
    // With no slot reaching the key, the insertion point is the end of the table.
    assign w_lookup_pos = w_any_at ? w_at_pos : r_count;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_nothing = r_nothing;
        n_pos     = r_pos;
        n_valid   = 1'b0;
        n_hit     = r_hit;
        n_out_pos = r_out_pos;
        n_first   = r_first;
        n_last_o  = r_last_o;
        n_value   = r_value;
        n_status  = r_status;
        w_act     = CA_HOLD;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state   = S_IDLE;
                n_valid   = 1'b1;
                n_hit     = 1'b0;
                n_out_pos = '0;
                n_first   = '0;
                n_last_o  = '0;
                n_value   = '0;
                n_status  = SS_OK;
                w_act     = CA_MARK_NONE;
                case (r_func)
                    FN_LOOKUP: begin
                        n_pos     = w_lookup_pos;
                        n_out_pos = POS_W'(w_lookup_pos);
                        if (w_any_hit) begin
                            n_hit    = 1'b1;
                            n_first  = w_at_low;
                            n_last_o = w_at_high;
                            n_value  = w_at_value;
                        end else begin
                            // The gap runs from past the previous entry to before the next.
                            n_status = SS_MISS;
                            n_first  = w_any_prev ? w_prev_high + 1'b1 : '0;
                            n_last_o = w_any_at ? w_at_low - 1'b1 : NO_UPPER;
                        end
                    end
                    FN_ADD: begin
                        n_pos     = w_lookup_pos;
                        n_out_pos = POS_W'(w_lookup_pos);
                        n_first   = r_key;
                        n_last_o  = r_last;
                        if (!w_any_ovl && r_count == CNT_W'(MAX_ENTRIES)) begin
                            n_status = SS_FULL;
                        end else begin
                            // Overlapping entries are dropped first, then the slot opens.
                            n_hit     = 1'b1;
                            n_value   = r_val;
                            n_nothing = 1'b0;
                            w_act     = CA_MARK_OVL;
                            n_state   = S_DROP;
                            n_valid   = 1'b0;
                        end
                    end
                    FN_REMOVE_CODE: begin
                        n_pos     = w_lookup_pos;
                        n_out_pos = POS_W'(w_lookup_pos);
                        if (w_any_hit) begin
                            n_hit    = 1'b1;
                            n_first  = w_at_low;
                            n_last_o = w_at_high;
                            n_value  = w_at_value;
                            w_act    = CA_MARK_HIT;
                            n_state  = S_DROP;
                            n_valid  = 1'b0;
                        end else begin
                            n_status = SS_MISS;
                        end
                    end
                    FN_REMOVE_RNG: begin
                        n_pos     = w_lookup_pos;
                        n_out_pos = POS_W'(w_lookup_pos);
                        n_first   = r_key;
                        n_last_o  = r_last;
                        if (w_any_ovl) begin
                            w_act   = CA_MARK_OVL;
                            n_state = S_DROP;
                            n_valid = 1'b0;
                        end else begin
                            n_status = SS_MISS;
                        end
                    end
                    FN_CLEAR: begin
                        n_count   = '0;
                        n_nothing = 1'b0;
                    end
                    FN_SET_NOTHING: begin
                        n_count   = '0;
                        n_nothing = 1'b1;
                    end
                    FN_READ_INDEX: begin
                        n_out_pos = POS_W'(r_idx);
                        if (w_idx_ok) begin
                            n_hit    = 1'b1;
                            n_first  = w_idx_low;
                            n_last_o = w_idx_high;
                            n_value  = w_idx_value;
                        end else begin
                            n_status = SS_BAD_INDEX;
                        end
                    end
                    default: begin
                        n_status = SS_OK;
                    end
                endcase
            end
            S_DROP: begin
                // Marked entries sit together from the located slot; drop one per cycle.
                if (w_mark_at_pos) begin
                    w_act   = CA_DROP;
                    n_count = r_count - 1'b1;
                end else if (r_func == FN_ADD) begin
                    n_state = S_INS;
                end else begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                end
            end
            S_INS: begin
                w_act   = CA_INS;
                n_count = r_count + 1'b1;
                n_state = S_IDLE;
                n_valid = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_nothing <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_nothing <= n_nothing;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_hit     <= n_hit;
        r_out_pos <= n_out_pos;
        r_first   <= n_first;
        r_last_o  <= n_last_o;
        r_value   <= n_value;
        r_status  <= n_status;
    end

    assign o_valid        = r_valid;
    assign o_hit          = r_hit;
    assign o_position     = r_out_pos;
    assign o_range_first  = r_first;
    assign o_range_last   = r_last_o;
    assign o_value_out    = r_value;
    assign o_entry_count  = POS_W'(r_count);
    assign o_nothing_flag = r_nothing;
    assign o_status       = r_status;

endmodule
